@@ design/lcle_pkg.sv @@
// Shared constants and control types for the LET chain latency evaluator.
`timescale 1ns / 1ps

package lcle_pkg;

  // Opcode carried on in_tuser
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_EVAL = 1'b1;

  // Default sizing of the task table
  localparam int DEF_MAX_TASKS = 8;
  localparam int DEF_TICK_BITS = 20;

  // Fixed field widths of the request and result
  localparam int IDX_BITS      = 3;
  localparam int FIELD_BITS    = 20;
  localparam int START_BITS    = 40;
  localparam int LAT_BITS      = 25;
  localparam int CNT_CFG_BITS  = 4;
  localparam int IN_DATA_BITS  = 104;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [CNT_CFG_BITS-1:0] TASK_COUNT_RST = 4'd1;

  // Sequencer to divider
  typedef struct packed {
    logic start;
  } lcle_div_ctl_t;

  // Divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lcle_div_sts_t;

endpackage

@@ design/lcle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcle_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lcle_div.sv @@
// Radix-2 restoring divider that returns the remainder of dividend by divisor.
`timescale 1ns / 1ps

module lcle_div
  import lcle_pkg::*;
#(
  parameter int TIME_W    = 41,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcle_div_ctl_t        ctl,
  input  logic [TIME_W-1:0]    dividend,
  input  logic [TICK_BITS-1:0] divisor,
  output lcle_div_sts_t        sts,
  output logic [TICK_BITS-1:0] remainder
);

  localparam int STEP_W = $clog2(TIME_W + 1);

  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_W-1:0]    dvd_r, dvd_nxt;
  logic [TICK_BITS-1:0] dsr_r, dsr_nxt;
  logic [TICK_BITS-1:0] rem_r, rem_nxt;
  logic [TICK_BITS:0]   rem_shift;

  // one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, dvd_r[TIME_W-1]};

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      step_nxt = STEP_W'(TIME_W);
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_W-2:0], 1'b0};
      if (rem_shift >= {1'b0, dsr_r}) begin
        rem_nxt = TICK_BITS'(rem_shift - {1'b0, dsr_r});
      end else begin
        rem_nxt = rem_shift[TICK_BITS-1:0];
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

@@ design/let_chain_latency_evaluator_core.sv @@
// Top level of the LET chain latency evaluator: sequencer, task table and divider.
`timescale 1ns / 1ps

// A load request (in_tuser = 0) writes one task entry (period, read offset,
// write offset) and returns no result; an index at or above
// MAX_TASKS is dropped. An evaluate request (in_tuser = 1) walks entries
// 0 .. min(task_count, MAX_TASKS)-1: for each entry it fetches the entry from
// the task RAM, takes the remainder of (t - read_offset) by the period on the
// shared radix-2 divider, moves t up to the next period boundary and adds the
// write offset. Rounding up to a boundary uses the remainder alone
// (k * period = d + period - r when r is nonzero), so no multiplier is needed.
// An entry with a zero period, or whose read offset is not before t, skips
// the divider; any other entry waits on the divider, which produces one
// quotient bit per cycle. in_tready is low while a request is in progress; a
// finished result is held in the output register while the next request is
// taken. The result is the final time minus start_time, saturated to the
// signed 25-bit range. Every entry walked must have been loaded; the task
// RAM has no reset. task_count (reset 1) is to be written through cfg_wr_en
// only while the block is idle; the block itself does not enforce this.
module let_chain_latency_evaluator_core
  import lcle_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // tdata, low bit up: task_index[3], task_period[20], read_offset[20],
  // write_offset[20], start_time[40], zero pad[1]
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // tuser: opcode[1]
  input  logic                     in_tuser,
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // tdata, low bit up: latency[25] (two's complement), zero pad[7]
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [CNT_CFG_BITS-1:0]  cfg_wr_data
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  // time grows by less than two periods per entry
  localparam int GROW_W = $clog2(MAX_TASKS) + TICK_BITS + 2;
  localparam int TIME_W = ((START_BITS > GROW_W) ? START_BITS : GROW_W) + 1;
  localparam int DIFF_W = TIME_W + 1;
  localparam int ENT_W  = 3 * TICK_BITS;

  localparam logic [DIFF_W-1:0] LAT_HI = DIFF_W'((64'd1 << (LAT_BITS - 1)) - 64'd1);
  localparam logic [DIFF_W-1:0] LAT_LO = ~LAT_HI;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PREP,
    S_DIV,
    S_ADJ,
    S_WOFS,
    S_DIFF,
    S_OUT
  } state_t;

  // request fields
  logic [IDX_BITS-1:0]   f_index;
  logic [FIELD_BITS-1:0] f_period;
  logic [FIELD_BITS-1:0] f_rd_ofs;
  logic [FIELD_BITS-1:0] f_wr_ofs;
  logic [START_BITS-1:0] f_start;

  assign f_index  = in_tdata[2:0];
  assign f_period = in_tdata[22:3];
  assign f_rd_ofs = in_tdata[42:23];
  assign f_wr_ofs = in_tdata[62:43];
  assign f_start  = in_tdata[102:63];

  state_t                  state_r, state_nxt;
  logic [CNT_CFG_BITS-1:0] task_count_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        n_cfg;
  logic                    out_valid_r, out_valid_nxt;
  logic [LAT_BITS-1:0]     out_lat_r, out_lat_nxt;
  logic [TIME_W-1:0]       t_r, t_nxt;
  logic [TIME_W-1:0]       d_r, d_nxt;
  logic [START_BITS-1:0]   start_r, start_nxt;
  logic [DIFF_W-1:0]       diff_r, diff_nxt;

  logic                    in_acc;
  logic                    ram_we;
  logic                    ram_re;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;
  logic [TICK_BITS-1:0]    e_period;
  logic [TICK_BITS-1:0]    e_rd_ofs;
  logic [TICK_BITS-1:0]    e_wr_ofs;
  logic [TIME_W:0]         rd_diff;
  logic                    past_read;
  logic                    last_entry;
  logic [TICK_BITS-1:0]    adj;

  lcle_div_ctl_t           div_ctl;
  lcle_div_sts_t           div_sts;
  logic [TICK_BITS-1:0]    div_rem;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // drop loads beyond the table
  assign ram_we    = in_acc && (in_tuser == OPC_LOAD) &&
                     (32'(f_index) < 32'(MAX_TASKS));
  assign ram_wdata = {TICK_BITS'(f_wr_ofs), TICK_BITS'(f_rd_ofs), TICK_BITS'(f_period)};
  assign ram_re    = (state_r == S_FETCH);

  lcle_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(f_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // read data holds until the next fetch, so the write offset is still there later
  assign e_period = ram_rdata[TICK_BITS-1:0];
  assign e_rd_ofs = ram_rdata[2*TICK_BITS-1:TICK_BITS];
  assign e_wr_ofs = ram_rdata[3*TICK_BITS-1:2*TICK_BITS];

  assign rd_diff   = {1'b0, t_r} - (TIME_W + 1)'(e_rd_ofs);
  assign past_read = !rd_diff[TIME_W] && (rd_diff != '0);
  assign last_entry = ((cnt_r + CNT_W'(1)) == n_r);

  // distance up to the next period boundary
  assign adj = (div_rem != '0) ? (e_period - div_rem) : '0;

  assign div_ctl.start = (state_r == S_PREP) && (e_period != '0) && past_read;

  lcle_div #(
    .TIME_W    (TIME_W),
    .TICK_BITS (TICK_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (rd_diff[TIME_W-1:0]),
    .divisor   (e_period),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  // saturate the walk length to the table depth
  assign n_cfg = (32'(task_count_r) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                      : CNT_W'(task_count_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_lat_nxt   = out_lat_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    start_nxt     = start_r;
    diff_nxt      = diff_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == OPC_EVAL)) begin
          t_nxt     = TIME_W'(f_start);
          start_nxt = f_start;
          cnt_nxt   = '0;
          n_nxt     = n_cfg;
          state_nxt = (n_cfg == '0) ? S_DIFF : S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        if (div_ctl.start) begin
          d_nxt     = rd_diff[TIME_W-1:0];
          state_nxt = S_DIV;
        end else begin
          // zero period or not yet past the read instant: k is zero
          t_nxt     = TIME_W'(e_wr_ofs);
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = last_entry ? S_DIFF : S_FETCH;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        t_nxt     = d_r + TIME_W'(adj);
        state_nxt = S_WOFS;
      end
      S_WOFS: begin
        // k * period = d rounded up; add back the write offset
        t_nxt     = t_r + TIME_W'(e_wr_ofs);
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = last_entry ? S_DIFF : S_FETCH;
      end
      S_DIFF: begin
        diff_nxt  = {1'b0, t_r} - DIFF_W'(start_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if ($signed(diff_r) > $signed(LAT_HI)) begin
            out_lat_nxt = LAT_HI[LAT_BITS-1:0];
          end else if ($signed(diff_r) < $signed(LAT_LO)) begin
            out_lat_nxt = LAT_LO[LAT_BITS-1:0];
          end else begin
            out_lat_nxt = diff_r[LAT_BITS-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= TASK_COUNT_RST;
      cnt_r        <= '0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        task_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_lat_r <= out_lat_nxt;
    t_r       <= t_nxt;
    d_r       <= d_nxt;
    start_r   <= start_nxt;
    diff_r    <= diff_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_BITS - LAT_BITS)'(0), out_lat_r};

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r <= n_r))
    else $error("entry counter ran past the walk length");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result overwrote a pending output");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the LET chain latency evaluator core.
`timescale 1ns / 1ps

module tb;
  import lcle_pkg::*;

  localparam int TASK_SLOTS = DEF_MAX_TASKS;

  // One request as the driver sees it, before packing onto the stream.
  typedef struct {
    logic                  op;
    logic [IDX_BITS-1:0]   idx;
    logic [FIELD_BITS-1:0] period;
    logic [FIELD_BITS-1:0] rd_ofs;
    logic [FIELD_BITS-1:0] wr_ofs;
    logic [START_BITS-1:0] start;
  } chain_req_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_tvalid   = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata    = '0;
  logic                     in_tuser    = OPC_LOAD;
  logic                     out_tvalid;
  logic                     out_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_wr_en   = 1'b0;
  logic [CNT_CFG_BITS-1:0]  cfg_wr_data = '0;

  // Local copy of the block state, advanced on every accepted request.
  logic [FIELD_BITS-1:0]   per_mem [TASK_SLOTS];
  logic [FIELD_BITS-1:0]   rdo_mem [TASK_SLOTS];
  logic [FIELD_BITS-1:0]   wro_mem [TASK_SLOTS];
  logic [CNT_CFG_BITS-1:0] chain_len = TASK_COUNT_RST;

  chain_req_t           pending_req_q [$];
  logic [LAT_BITS-1:0]  expected_latency_q [$];
  chain_req_t           held_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  let_chain_latency_evaluator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Walk the chain from start: each entry rounds t up to its next period
  // boundary past the read offset, then adds the write offset.
  function automatic logic [LAT_BITS-1:0] chain_latency(input logic [START_BITS-1:0] start);
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] k;
    logic [63:0] per;
    longint      lat;
    int          n;
    t = 64'(start);
    n = (chain_len > TASK_SLOTS) ? TASK_SLOTS : int'(chain_len);
    for (int i = 0; i < n; i++) begin
      per = 64'(per_mem[i]);
      k = 0;
      // zero period, or t at or before the read offset, leaves k at zero
      if (per != 0 && t > 64'(rdo_mem[i])) begin
        d = t - 64'(rdo_mem[i]);
        k = d / per;
        if (d % per != 0) begin
          k++;
        end
      end
      t = k * per + 64'(wro_mem[i]);
    end
    lat = $signed(t) - $signed(64'(start));
    // clamp to the signed 25-bit result range
    if (lat < -64'sd16777216) begin
      lat = -64'sd16777216;
    end
    if (lat > 64'sd16777215) begin
      lat = 64'sd16777215;
    end
    return lat[LAT_BITS-1:0];
  endfunction

  // Apply one accepted request: a load updates the table, an evaluate
  // queues its expected latency.
  function automatic void step_chain(input chain_req_t r);
    if (r.op == OPC_LOAD) begin
      if (int'(r.idx) < TASK_SLOTS) begin
        per_mem[r.idx] = r.period;
        rdo_mem[r.idx] = r.rd_ofs;
        wro_mem[r.idx] = r.wr_ofs;
      end
    end else begin
      expected_latency_q.push_back(chain_latency(r.start));
    end
  endfunction

  // Driver: predict at the accepting edge, then offer the next request
  // unless this cycle is an idle one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_chain(held_req);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = pending_req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, held_req.start, held_req.wr_ofs, held_req.rd_ofs,
                        held_req.period, held_req.idx};
          in_tuser  <= held_req.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation,
  // and stall the result channel at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_latency_q.size() == 0) begin
          note_fail($sformatf("unexpected result, latency %0d",
                              $signed(out_tdata[LAT_BITS-1:0])));
        end else begin
          logic [LAT_BITS-1:0] want;
          want = expected_latency_q.pop_front();
          if (out_tdata[LAT_BITS-1:0] !== want) begin
            note_fail($sformatf("latency mismatch: expected %0d, got %0d",
                                $signed(want), $signed(out_tdata[LAT_BITS-1:0])));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_load(input int idx, input int per, input int rdo, input int wro);
    chain_req_t r;
    r.op     = OPC_LOAD;
    r.idx    = idx[IDX_BITS-1:0];
    r.period = per[FIELD_BITS-1:0];
    r.rd_ofs = rdo[FIELD_BITS-1:0];
    r.wr_ofs = wro[FIELD_BITS-1:0];
    r.start  = {8'($urandom), 32'($urandom)};
    pending_req_q.push_back(r);
  endtask

  task automatic push_eval(input logic [START_BITS-1:0] start);
    chain_req_t r;
    r.op     = OPC_EVAL;
    r.idx    = 3'($urandom);
    r.period = 20'($urandom);
    r.rd_ofs = 20'($urandom);
    r.wr_ofs = 20'($urandom);
    r.start  = start;
    pending_req_q.push_back(r);
  endtask

  // Mostly short periods so the chain stays near the start time, with
  // full-width and zero values mixed in.
  function automatic int rand_period();
    case ($urandom_range(9))
      0:       return 0;
      1, 2, 3: return $urandom_range(64, 1);
      4, 5, 6: return $urandom_range(4096, 1);
      default: return $urandom & 20'hFFFFF;
    endcase
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(3))
      0:       return 0;
      1:       return $urandom_range(4096);
      default: return $urandom & 20'hFFFFF;
    endcase
  endfunction

  function automatic logic [START_BITS-1:0] rand_start();
    case ($urandom_range(3))
      0:       return 40'($urandom_range(1 << 21));
      1:       return 40'($urandom_range(1 << 26));
      2:       return {8'($urandom), 32'($urandom)};
      default: return 40'hFF_FFFF_FFFF - 40'($urandom_range(1 << 22));
    endcase
  endfunction

  // Wait until every request is taken and every result is back, then
  // keep waiting so that no load is still in flight.
  task automatic drain();
    do @(posedge clk);
    while (pending_req_q.size() != 0 || in_tvalid || expected_latency_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [CNT_CFG_BITS-1:0] n);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    chain_len = n;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  initial begin
    logic [CNT_CFG_BITS-1:0] counts [8];
    counts = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd2, 4'd8, 4'd8};
    counts[6] = 4'($urandom_range(8, 1));
    counts[7] = 4'($urandom_range(15));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: load every entry with the field extremes, including a zero
    // period, then evaluate under the reset chain length of one.
    push_load(0, 1000, 20, 5);
    push_load(1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    push_load(2, 0, 5, 100);
    push_load(3, 1000, 300, 7);
    push_load(4, 7, 20'hFFFFF, 0);
    push_load(5, 20'hFFFFF, 0, 20'hFFFFF);
    push_load(6, 1, 1, 2);
    push_load(7, 20'h80000, 20'h12345, 20'hABCDE);
    push_eval(40'd0);
    push_eval(40'hFF_FFFF_FFFF);
    push_eval(40'd20);
    drain();

    // Full chain of eight.
    set_task_count(4'd8);
    push_eval(40'd0);
    push_eval(40'hFF_FFFF_FFFF);
    push_eval(40'd1048575);
    push_eval(40'd123456789);
    drain();

    // Empty chain yields zero latency.
    set_task_count(4'd0);
    push_eval(40'd555);
    push_eval(40'hFF_FFFF_FFFF);
    drain();

    // Count above the table size saturates to the full chain.
    set_task_count(4'd15);
    push_eval(40'd0);
    push_eval(40'd98765);
    drain();

    // Random phases: reload entries and evaluate, cycling chain lengths
    // and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_task_count(counts[ph]);
      set_idling(ph % 4);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(9) < 4) begin
          push_load($urandom_range(TASK_SLOTS - 1), rand_period(), rand_offset(),
                    rand_offset());
        end else begin
          push_eval(rand_start());
        end
      end
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (400) @(posedge clk);
    if (expected_latency_q.size() != 0) begin
      note_fail($sformatf("%0d results never arrived", expected_latency_q.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
